### rtl/core/tdf_pkg.sv
package tdf_pkg;

  localparam int unsigned AttemptSlots = 3;
  localparam logic [13:0] YearMinReset = 14'd2000;
  localparam logic [13:0] YearMaxReset = 14'd2099;
  localparam logic [13:0] NumSat = 14'd16383;
  localparam logic [11:0] AllMonths = 12'hFFF;

  localparam logic [0:0] RegYearMin = 1'b0;
  localparam logic [0:0] RegYearMax = 1'b1;

  typedef enum logic [8:0] {
    PhIdle  = 9'b000000001,
    PhDay   = 9'b000000010,
    PhMpre  = 9'b000000100,
    PhMsign = 9'b000001000,
    PhMonth = 9'b000010000,
    PhYear  = 9'b000100000,
    PhNsp   = 9'b001000000,
    PhNlet  = 9'b010000000,
    PhNsp2  = 9'b100000000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [4:0]  day;
    logic        sep;
    logic [3:0]  month;
    logic [13:0] number;
    logic [2:0]  digits;
    logic [11:0] match;
    logic [3:0]  letters;
  } slot_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic        date_found;
    logic [13:0] year_value;
    logic [3:0]  month_value;
    logic [4:0]  day_value;
  } out_t;

  typedef struct packed {
    logic        hit;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } hit_t;

  function automatic slot_t idle_slot();
    slot_t s;
    s = '0;
    s.phase = PhIdle;
    s.match = AllMonths;
    return s;
  endfunction

  function automatic logic [7:0] month_char(input logic [3:0] m, input logic [3:0] p);
    logic [71:0] t;
    logic [3:0] len;
    case (m)
      4'd0: begin t = "january  "; len = 4'd7; end
      4'd1: begin t = "february "; len = 4'd8; end
      4'd2: begin t = "march    "; len = 4'd5; end
      4'd3: begin t = "april    "; len = 4'd5; end
      4'd4: begin t = "may      "; len = 4'd3; end
      4'd5: begin t = "june     "; len = 4'd4; end
      4'd6: begin t = "july     "; len = 4'd4; end
      4'd7: begin t = "august   "; len = 4'd6; end
      4'd8: begin t = "september"; len = 4'd9; end
      4'd9: begin t = "october  "; len = 4'd7; end
      4'd10: begin t = "november "; len = 4'd8; end
      default: begin t = "december "; len = 4'd8; end
    endcase
    if (p >= len) return 8'h00;
    return t[71 - 8 * p -: 8];
  endfunction

endpackage

### rtl/core/tdf_cell.sv
module tdf_cell (
  input  tdf_pkg::slot_t cur_i,
  input  logic [7:0]     c_i,
  input  logic [13:0]    year_min_i,
  input  logic [13:0]    year_max_i,
  output tdf_pkg::slot_t nxt_o,
  output tdf_pkg::hit_t  hit_o
);

  logic dig, alpha, white, sp;
  logic [3:0] d;
  logic [17:0] acc;
  logic [13:0] accs;
  logic [11:0] keep;
  logic [3:0] first;
  logic [7:0] lc;

  assign dig = (c_i >= 8'h30) && (c_i <= 8'h39);
  assign alpha = ((c_i | 8'h20) >= 8'h61) && ((c_i | 8'h20) <= 8'h7a);
  assign white = (c_i == 8'h20) || ((c_i >= 8'd9) && (c_i <= 8'd13));
  assign sp = (c_i == 8'h20);
  assign d = dig ? c_i[3:0] : 4'd0;
  assign lc = c_i | 8'h20;
  assign acc = {1'b0, cur_i.number, 3'b0} + {3'b0, cur_i.number, 1'b0} + {14'd0, d};
  assign accs = (acc > {4'd0, tdf_pkg::NumSat}) ? tdf_pkg::NumSat : acc[13:0];

  always_comb begin
    keep = '0;
    for (int m = 0; m < 12; m++) begin
      keep[m] = cur_i.match[m] && (tdf_pkg::month_char(4'(m), cur_i.letters) == lc);
    end
    first = 4'd0;
    for (int m = 11; m >= 0; m--) begin
      if (cur_i.match[m]) first = 4'(m);
    end
  end

  always_comb begin
    nxt_o = cur_i;
    hit_o = '0;
    unique case (cur_i.phase)
      tdf_pkg::PhDay: begin
        if (dig) begin
          nxt_o.number = accs;
        end else if (cur_i.number < 14'd1 || cur_i.number > 14'd31) begin
          nxt_o.phase = tdf_pkg::PhIdle;
        end else begin
          nxt_o.day = cur_i.number[4:0];
          if (c_i == 8'h2d || c_i == 8'h2f) begin
            nxt_o.sep = (c_i == 8'h2f);
            nxt_o.phase = tdf_pkg::PhMpre;
          end else if (sp) begin
            nxt_o.phase = tdf_pkg::PhNsp;
          end else if (alpha) begin
            nxt_o.phase = tdf_pkg::PhNlet;
            nxt_o.match = AllMonthsKeep(lc);
            nxt_o.letters = 4'd1;
          end else begin
            nxt_o.phase = tdf_pkg::PhIdle;
          end
        end
      end
      tdf_pkg::PhMpre, tdf_pkg::PhMsign: begin
        if (cur_i.phase == tdf_pkg::PhMpre && white) begin
          nxt_o.phase = tdf_pkg::PhMpre;
        end else if (cur_i.phase == tdf_pkg::PhMpre && c_i == 8'h2b) begin
          nxt_o.phase = tdf_pkg::PhMsign;
        end else if (dig) begin
          nxt_o.phase = tdf_pkg::PhMonth;
          nxt_o.number = {10'd0, d};
        end else begin
          nxt_o.phase = tdf_pkg::PhIdle;
        end
      end
      tdf_pkg::PhMonth: begin
        if (dig) begin
          nxt_o.number = accs;
        end else if (cur_i.number >= 14'd1 && cur_i.number <= 14'd12 &&
                     c_i == (cur_i.sep ? 8'h2f : 8'h2d)) begin
          nxt_o.month = cur_i.number[3:0];
          nxt_o.phase = tdf_pkg::PhYear;
          nxt_o.number = '0;
          nxt_o.digits = '0;
        end else begin
          nxt_o.phase = tdf_pkg::PhIdle;
        end
      end
      tdf_pkg::PhYear: begin
        if (dig) begin
          nxt_o.number = accs;
          if (cur_i.digits < 3'd7) nxt_o.digits = cur_i.digits + 3'd1;
        end else begin
          hit_o.hit = (cur_i.digits == 3'd4) && (cur_i.number >= year_min_i) &&
                      (cur_i.number <= year_max_i);
          hit_o.year = cur_i.number;
          hit_o.month = cur_i.month;
          hit_o.day = cur_i.day;
          nxt_o.phase = tdf_pkg::PhIdle;
        end
      end
      tdf_pkg::PhNsp: begin
        if (sp) begin
          nxt_o.phase = tdf_pkg::PhNsp;
        end else if (alpha) begin
          nxt_o.phase = tdf_pkg::PhNlet;
          nxt_o.match = AllMonthsKeep(lc);
          nxt_o.letters = 4'd1;
        end else begin
          nxt_o.phase = tdf_pkg::PhIdle;
        end
      end
      tdf_pkg::PhNlet, tdf_pkg::PhNsp2: begin
        if (cur_i.phase == tdf_pkg::PhNlet && alpha) begin
          nxt_o.match = keep;
          if (cur_i.letters != 4'd15) nxt_o.letters = cur_i.letters + 4'd1;
        end else if (cur_i.phase == tdf_pkg::PhNlet &&
                     (cur_i.letters < 4'd3 || cur_i.match == '0)) begin
          nxt_o.phase = tdf_pkg::PhIdle;
        end else begin
          if (cur_i.phase == tdf_pkg::PhNlet) nxt_o.month = first + 4'd1;
          if (sp) begin
            nxt_o.phase = tdf_pkg::PhNsp2;
          end else if (dig) begin
            nxt_o.phase = tdf_pkg::PhYear;
            nxt_o.number = {10'd0, d};
            nxt_o.digits = 3'd1;
          end else begin
            nxt_o.phase = tdf_pkg::PhIdle;
          end
        end
      end
      default: nxt_o.phase = tdf_pkg::PhIdle;
    endcase
  end

  function automatic logic [11:0] AllMonthsKeep(input logic [7:0] ch);
    logic [11:0] k;
    for (int m = 0; m < 12; m++) begin
      k[m] = (tdf_pkg::month_char(4'(m), 4'd0) == ch);
    end
    return k;
  endfunction

endmodule

### rtl/core/text_date_finder_core.sv
// Channel | Valid     | Stall     | Payload
// in      | in_valid_i | in_stall_o | in_data_i (tdf_pkg::in_t)
// out     | out_valid_o | out_stall_i | out_data_o (tdf_pkg::out_t)
// cfg     | psel/penable | pready=1 | paddr/pwdata
// One byte per cycle unless stalled; all slot cells step in parallel.
// A result appears the cycle after the byte carrying the last mark.
// Input stalls while a finished result waits and the output is stalled.
// Reset clears all slots and restores the year window to 2000..2099.
module text_date_finder_core #(
  parameter int unsigned AttemptSlots = tdf_pkg::AttemptSlots
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tdf_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tdf_pkg::out_t  out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  tdf_pkg::slot_t slot_q [AttemptSlots];
  tdf_pkg::slot_t step1 [AttemptSlots];
  tdf_pkg::slot_t step2 [AttemptSlots];
  tdf_pkg::slot_t comp [AttemptSlots];
  tdf_pkg::slot_t next_d [AttemptSlots];
  tdf_pkg::hit_t  hit1 [AttemptSlots];
  tdf_pkg::hit_t  hit2 [AttemptSlots];
  logic [13:0] year_min_q, year_max_q;
  logic prev_dig_q, latched_q;
  logic [22:0] date_q;
  logic in_acc, dig, is_last;
  logic out_acc;
  logic latched_d;
  logic [22:0] date_d, date_fin;
  logic found_fin;

  assign pready = 1'b1;
  assign prdata = {18'd0, (paddr[2] ? year_max_q : year_min_q)};
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o = out_valid_o && out_stall_i;
  assign dig = (in_data_i.char_code >= 8'h30) && (in_data_i.char_code <= 8'h39);
  assign is_last = in_data_i.last_char;

  for (genvar g = 0; g < AttemptSlots; g++) begin : g_cell
    tdf_cell u_a (.cur_i(slot_q[g]), .c_i(in_data_i.char_code),
      .year_min_i(year_min_q), .year_max_i(year_max_q), .nxt_o(step1[g]), .hit_o(hit1[g]));
    tdf_cell u_b (.cur_i(comp[g]), .c_i(8'h00),
      .year_min_i(year_min_q), .year_max_i(year_max_q), .nxt_o(step2[g]), .hit_o(hit2[g]));
  end

  always_comb begin
    int k;
    k = 0;
    for (int i = 0; i < AttemptSlots; i++) comp[i] = tdf_pkg::idle_slot();
    for (int i = 0; i < AttemptSlots; i++) begin
      if (step1[i].phase != tdf_pkg::PhIdle) begin
        comp[k] = step1[i];
        k = k + 1;
      end
    end
    if (dig && !prev_dig_q && k < AttemptSlots) begin
      comp[k].phase = tdf_pkg::PhDay;
      comp[k].number = {10'd0, in_data_i.char_code[3:0]};
    end
    latched_d = latched_q;
    date_d = date_q;
    for (int i = 0; i < AttemptSlots; i++) begin
      if (hit1[i].hit && !latched_d) begin
        latched_d = 1'b1;
        date_d = {hit1[i].year, hit1[i].month, hit1[i].day};
      end
    end
    found_fin = latched_d;
    date_fin = date_d;
    for (int i = 0; i < AttemptSlots; i++) begin
      if (hit2[i].hit && !found_fin) begin
        found_fin = 1'b1;
        date_fin = {hit2[i].year, hit2[i].month, hit2[i].day};
      end
    end
    for (int i = 0; i < AttemptSlots; i++) next_d[i] = is_last ? tdf_pkg::idle_slot() : comp[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AttemptSlots; i++) slot_q[i] <= tdf_pkg::idle_slot();
      prev_dig_q <= 1'b0;
      latched_q <= 1'b0;
      date_q <= '0;
      out_valid_o <= 1'b0;
      out_data_o <= '0;
      year_min_q <= tdf_pkg::YearMinReset;
      year_max_q <= tdf_pkg::YearMaxReset;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == tdf_pkg::RegYearMax) year_max_q <= pwdata[13:0];
        else year_min_q <= pwdata[13:0];
      end
      if (in_acc && is_last) begin
        out_valid_o <= 1'b1;
        out_data_o <= {found_fin, found_fin ? date_fin : 23'd0};
      end else if (out_acc) begin
        out_valid_o <= 1'b0;
      end
      if (in_acc) begin
        slot_q <= next_d;
        prev_dig_q <= is_last ? 1'b0 : dig;
        latched_q <= is_last ? 1'b0 : latched_d;
        date_q <= is_last ? '0 : date_d;
      end
    end
  end

  a_latch_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latched_q && !(in_acc && is_last) |=> latched_q)
    else $error("latched date lost");
  a_found_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.date_found |-> out_data_o.year_value == 14'd0)
    else $error("year without date");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped");

endmodule
